// ===== rtl/core/smms_pkg.sv =====
// shared types and constants for the shared-memory multi-stack block
package smms_pkg;

    // default sizing
    localparam int unsigned MEMORY_DEPTH_DEF    = 16;
    localparam int unsigned MAX_STACK_COUNT_DEF = 8;
    localparam int unsigned DATA_WIDTH_DEF      = 32;

    // fixed field widths
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned WORD_W = 32;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // request operation codes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // request sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/shared_memory_multi_stack.sv =====
// top level: several stacks sharing one segmented word memory
//
// Input channel s_*: a request carries s_kind (0 push, 1 pop), s_stack_index
// and s_push_value, taken when s_valid and s_ready are both high. Result
// channel m_*: m_status (0 ok, 1 full, 2 empty, 3 bad index) and m_pop_value,
// taken when m_valid and m_ready are both high. One result per request.
// cfg_we/cfg_wdata write the stack count; it resets every stack pointer and
// may only be written while no request is in flight.
// Path: a taken request and its pointer read are registered, then the
// finished result and the word memory read of a pop, then the output
// register. While a request is in flight, the next one is taken only in
// the cycle the current result moves to the output register, so a new
// request waits until the current one is through. The output register
// holds a finished result while the next request is already being worked on.
// Stall: while m_ready is low and the output register is full, a finished
// result waits in the sequencer and s_ready stays low.
// Reset (aresetn low at a clock edge): one stack over the whole memory,
// every stack empty, no result pending. No clearing pass is needed: per-stack
// valid bits mark written pointers; one with its bit clear reads as its base.
module shared_memory_multi_stack #(
    parameter int unsigned MEMORY_DEPTH    = smms_pkg::MEMORY_DEPTH_DEF,
    parameter int unsigned MAX_STACK_COUNT = smms_pkg::MAX_STACK_COUNT_DEF,
    parameter int unsigned DATA_WIDTH      = smms_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [smms_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [smms_pkg::IDX_W-1:0]   s_stack_index,
    input  logic [smms_pkg::WORD_W-1:0]  s_push_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [smms_pkg::WORD_W-1:0]  m_pop_value
);

    localparam int unsigned AW = $clog2(MEMORY_DEPTH);
    localparam int unsigned PW = $clog2(MEMORY_DEPTH + 1);
    localparam int unsigned PA = (MAX_STACK_COUNT > 1) ? $clog2(MAX_STACK_COUNT) : 1;
    localparam int unsigned CW = $clog2(MAX_STACK_COUNT + 1);

    // segment size for each stack count, worked out at elaboration
    logic [PW-1:0] seg_table [1:MAX_STACK_COUNT];
    for (genvar K = 1; K <= MAX_STACK_COUNT; K++) begin : g_seg
        assign seg_table[K] = PW'(MEMORY_DEPTH / K);
    end

    smms_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg;
    logic [PW-1:0]     seg_reg;
    logic [MAX_STACK_COUNT-1:0] valid_reg;
    logic [PW-1:0]     ptr_mem [MAX_STACK_COUNT];
    logic [PW-1:0]     ptr_rd_reg;

    // captured request
    logic                        kind_reg;
    logic [smms_pkg::IDX_W-1:0]  idx_reg;
    logic [DATA_WIDTH-1:0]       word_reg;
    logic                        bad_reg;
    logic [PW-1:0]               base_reg;
    logic [PW-1:0]               limit_reg;

    // finished result waiting for the output register
    smms_pkg::status_t status_reg, status_next;
    logic              pop_ok_reg, pop_ok_next;

    // output register
    logic                        m_valid_reg;
    smms_pkg::status_t           m_status_reg;
    logic [smms_pkg::WORD_W-1:0] m_pop_value_reg;

    logic          out_free;
    logic          accept;
    logic          load_out;
    logic [CW-1:0] eff_count;
    logic [PW-1:0] acc_base;
    logic          acc_last;
    logic [PA-1:0] pidx;
    logic [PW-1:0] top;
    logic          ptr_we;
    logic [PW-1:0] ptr_wdata;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign pidx     = PA'(idx_reg);

    // effective stack count from the register write
    always_comb begin
        if (cfg_wdata == '0) begin
            eff_count = CW'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_STACK_COUNT)) begin
            eff_count = CW'(MAX_STACK_COUNT);
        end else begin
            eff_count = CW'(cfg_wdata);
        end
    end

    // segment bounds of the incoming request
    assign acc_base = PW'(seg_reg * PW'(s_stack_index));
    assign acc_last = (32'(s_stack_index) + 32'd1) >= 32'(count_reg);

    // current top: a pointer not written since reset or reconfiguration is its base
    assign top = valid_reg[pidx] ? ptr_rd_reg : base_reg;

    // sequencer next state and memory controls
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        load_out    = 1'b0;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        ptr_we      = 1'b0;
        ptr_wdata   = top;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = AW'(top - PW'(1));
        unique case (state_reg)
            smms_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = smms_pkg::S_LOOK;
                end
            end
            smms_pkg::S_LOOK: begin
                pop_ok_next = 1'b0;
                if (bad_reg) begin
                    status_next = smms_pkg::ST_BADIDX;
                end else if (kind_reg == smms_pkg::OP_PUSH) begin
                    if (top >= limit_reg) begin
                        status_next = smms_pkg::ST_FULL;
                    end else begin
                        status_next = smms_pkg::ST_OK;
                        ram_we      = 1'b1;
                        ptr_we      = 1'b1;
                        ptr_wdata   = top + PW'(1);
                    end
                end else begin
                    if (top <= base_reg) begin
                        status_next = smms_pkg::ST_EMPTY;
                    end else begin
                        status_next = smms_pkg::ST_OK;
                        pop_ok_next = 1'b1;
                        ram_re      = 1'b1;
                        ptr_we      = 1'b1;
                        ptr_wdata   = top - PW'(1);
                    end
                end
                state_next = smms_pkg::S_DONE;
            end
            smms_pkg::S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    s_ready  = 1'b1;
                    state_next = s_valid ? smms_pkg::S_LOOK : smms_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = smms_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smms_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // stack count, segment size and pointer valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(1);
            seg_reg   <= PW'(MEMORY_DEPTH);
            valid_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= eff_count;
            seg_reg   <= seg_table[eff_count];
            valid_reg <= '0;
        end else if (ptr_we) begin
            valid_reg[pidx] <= 1'b1;
        end
    end

    // pointer memory: read on request, write back after the update
    always_ff @(posedge aclk) begin
        if (ptr_we) begin
            ptr_mem[pidx] <= ptr_wdata;
        end
        if (accept) begin
            ptr_rd_reg <= ptr_mem[PA'(s_stack_index)];
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            idx_reg   <= s_stack_index;
            word_reg  <= DATA_WIDTH'(s_push_value);
            bad_reg   <= 32'(s_stack_index) >= 32'(count_reg);
            base_reg  <= acc_base;
            limit_reg <= acc_last ? PW'(MEMORY_DEPTH) : acc_base + seg_reg;
        end
    end

    // finished result
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
    end

    smms_word_ram #(
        .DEPTH (MEMORY_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(top)),
        .wr_data (word_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg    <= status_reg;
            m_pop_value_reg <= pop_ok_reg ? smms_pkg::WORD_W'(ram_rdata) : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_pop_value = m_pop_value_reg;

endmodule

// ===== rtl/core/smms_word_ram.sv =====
// word memory shared by all stacks: one write port, one registered read port
module smms_word_ram #(
    parameter int unsigned DEPTH = smms_pkg::MEMORY_DEPTH_DEF,
    parameter int unsigned WIDTH = smms_pkg::DATA_WIDTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== test/shared_memory_multi_stack_test.sv =====
// self-checking testbench for the shared-memory multi-stack block
module shared_memory_multi_stack_test;

    localparam int unsigned DEPTH       = smms_pkg::MEMORY_DEPTH_DEF;
    localparam int unsigned STACK_LIMIT = smms_pkg::MAX_STACK_COUNT_DEF;
    localparam int unsigned IDLE_LIMIT  = 2000;

    // one expected result
    typedef struct {
        smms_pkg::status_t           status;
        logic [smms_pkg::WORD_W-1:0] pop_value;
    } stack_result_t;

    // predictor of the stack memory plus the queue of expected results
    class stack_scoreboard;
        logic [smms_pkg::WORD_W-1:0] word_mem [DEPTH];
        int unsigned       top_ptr [STACK_LIMIT];
        int unsigned       seg_base [STACK_LIMIT + 1];
        int unsigned       stack_count;
        stack_result_t     pending_results [$];
        int unsigned       mismatch_count;
        int unsigned       fail_count;

        function new();
            foreach (word_mem[i]) word_mem[i] = '0;
            mismatch_count = 0;
            fail_count     = 0;
            set_stack_count(smms_pkg::CFG_W'(1));
        endfunction

        // zero counts as one stack, large values clamp to the maximum
        function void set_stack_count(logic [smms_pkg::CFG_W-1:0] raw);
            int unsigned seg;
            stack_count = (raw == 0) ? 1 : int'(raw);
            if (stack_count > STACK_LIMIT) stack_count = STACK_LIMIT;
            seg = DEPTH / stack_count;
            for (int k = 0; k < STACK_LIMIT; k++) begin
                seg_base[k] = (k < stack_count) ? seg * k : DEPTH;
                top_ptr[k]  = seg_base[k];
            end
            seg_base[stack_count] = DEPTH;
            seg_base[STACK_LIMIT] = DEPTH;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // apply one accepted request to the stack model
        function void note_request(smms_pkg::op_t kind, logic [smms_pkg::IDX_W-1:0] idx,
                                   logic [smms_pkg::WORD_W-1:0] word);
            stack_result_t res;
            int unsigned   t;
            res.status    = smms_pkg::ST_OK;
            res.pop_value = '0;
            if (idx >= stack_count) begin
                res.status = smms_pkg::ST_BADIDX;
            end else if (kind == smms_pkg::OP_PUSH) begin
                t = top_ptr[idx];
                if (t >= seg_base[idx + 1] || t >= DEPTH) begin
                    res.status = smms_pkg::ST_FULL;
                end else begin
                    word_mem[t]  = word;
                    top_ptr[idx] = t + 1;
                end
            end else begin
                t = top_ptr[idx];
                if (t <= seg_base[idx] || t == 0) begin
                    res.status = smms_pkg::ST_EMPTY;
                end else begin
                    res.pop_value = word_mem[t - 1];
                    top_ptr[idx]  = t - 1;
                end
            end
            pending_results.push_back(res);
        endfunction

        // compare one accepted result with the oldest expected one
        function void check_result(logic [1:0] status, logic [smms_pkg::WORD_W-1:0] value);
            stack_result_t want;
            if (pending_results.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d pop_value %h", status, value);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || value !== want.pop_value) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display(
                        "result differs: status expected %0d got %0d, value expected %h got %h",
                        want.status, status, want.pop_value, value);
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_we;
    logic [smms_pkg::CFG_W-1:0]    cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_kind;
    logic [smms_pkg::IDX_W-1:0]    s_stack_index;
    logic [smms_pkg::WORD_W-1:0]   s_push_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [1:0]                    m_status;
    logic [smms_pkg::WORD_W-1:0]   m_pop_value;

    stack_scoreboard sb = new();
    bit              tx_idle_on = 1'b1;
    bit              rx_idle_on = 1'b1;
    int unsigned     idle_cycles = 0;

    shared_memory_multi_stack DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_stack_index (s_stack_index),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_pop_value   (m_pop_value)
    );

    // clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random ready gaps, check at the rising edge
    initial begin
        bit          taken;
        int unsigned rx_wait;
        m_ready = 1'b0;
        rx_wait = 0;
        forever begin
            @(posedge aclk);
            taken = aresetn && m_valid && m_ready;
            if (taken) sb.check_result(m_status, m_pop_value);
            @(negedge aclk);
            if (taken) rx_wait = rx_idle_on ? $urandom_range(0, 12) : 0;
            if (rx_wait > 0) begin
                m_ready = 1'b0;
                rx_wait--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("shared_memory_multi_stack: mismatch");
                    $finish;
                end
            end
        end
    end

    // offer one request after a random gap, return at the falling edge
    task automatic send_request(input smms_pkg::op_t kind,
                                input logic [smms_pkg::IDX_W-1:0] idx,
                                input logic [smms_pkg::WORD_W-1:0] word);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_kind        = kind;
        s_stack_index = idx;
        s_push_value  = word;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, idx, word);
        @(negedge aclk);
    endtask

    // hold requests back until every result has arrived
    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // stack count write, only while the block is idle
    task automatic write_stack_count(input logic [smms_pkg::CFG_W-1:0] value);
        drain_results();
        repeat (4) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.set_stack_count(value);
    endtask

    initial begin
        logic [smms_pkg::CFG_W-1:0]  phase_counts [$];
        logic [smms_pkg::IDX_W-1:0]  idx;
        logic [smms_pkg::WORD_W-1:0] word;
        smms_pkg::op_t               kind;
        int unsigned                 push_pct;
        int unsigned                 sel;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_kind        = smms_pkg::OP_PUSH;
        s_stack_index = '0;
        s_push_value  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset state: one stack over the whole memory
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);
        send_request(smms_pkg::OP_PUSH, 3'd0, 32'h0000_0000);
        send_request(smms_pkg::OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h1234_5678);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);
        send_request(smms_pkg::OP_PUSH, 3'd1, 32'hDEAD_BEEF);
        send_request(smms_pkg::OP_POP,  3'd7, 32'h0);

        // eight stacks of two words: full, empty and last segment
        write_stack_count(4'd8);
        send_request(smms_pkg::OP_PUSH, 3'd0, 32'h0000_0001);
        send_request(smms_pkg::OP_PUSH, 3'd0, 32'h8000_0000);
        send_request(smms_pkg::OP_PUSH, 3'd0, 32'hFFFF_FFFF);
        send_request(smms_pkg::OP_POP,  3'd7, 32'h0);
        send_request(smms_pkg::OP_PUSH, 3'd7, 32'h5555_5555);
        send_request(smms_pkg::OP_PUSH, 3'd7, 32'hAAAA_AAAA);
        send_request(smms_pkg::OP_PUSH, 3'd7, 32'h0F0F_0F0F);
        send_request(smms_pkg::OP_POP,  3'd7, 32'h0);
        send_request(smms_pkg::OP_POP,  3'd7, 32'h0);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);
        send_request(smms_pkg::OP_POP,  3'd0, 32'h0);

        // random phases over several stack counts, zero and clamped ones included
        phase_counts = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd9, 4'd5, 4'd2, 4'd6, 4'd7, 4'd4};
        phase_counts.push_back(smms_pkg::CFG_W'($urandom_range(0, 15)));
        phase_counts.push_back(4'd8);
        foreach (phase_counts[p]) begin
            write_stack_count(phase_counts[p]);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            push_pct   = 50;
            for (int n = 0; n < 82; n++) begin
                // bursts that lean toward push or pop to reach full and empty
                if (n % 16 == 0) push_pct = $urandom_range(10, 90);
                kind = ($urandom_range(0, 99) < push_pct) ? smms_pkg::OP_PUSH
                                                          : smms_pkg::OP_POP;
                if ($urandom_range(0, 99) < 85)
                    idx = smms_pkg::IDX_W'($urandom_range(0, sb.stack_count - 1));
                else
                    idx = smms_pkg::IDX_W'($urandom_range(0, 7));
                sel = $urandom_range(0, 7);
                if (sel == 0)      word = '0;
                else if (sel == 1) word = '1;
                else               word = $urandom;
                if ($urandom_range(0, 63) == 0) drain_results();
                send_request(kind, idx, word);
            end
        end

        // let the last results arrive, then a short tail
        drain_results();
        repeat (8) @(negedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("shared_memory_multi_stack: match");
        end else begin
            $display("shared_memory_multi_stack: mismatch");
        end
        $finish;
    end

endmodule
